@@ src/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// coordinate, error term and color widths, command codes, line state types
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_BITS  = 10;
  localparam int DEC_BITS    = COORD_BITS + 3;
  localparam int COLOR_BITS  = 8;

  localparam int IN_FIELDS_W  = 4 * COORD_BITS + 3 * COLOR_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COORD_BITS + 3 * COLOR_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // command selector carried in tuser
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] red;
  } color_t;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t stop_x;
    coord_t stop_y;
    coord_t span_x;
    coord_t span_y;
    dec_t   decision;
    logic   y_down;
    logic   steep;
  } line_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

endpackage

@@ src/lr_load.sv @@
// ----------------------------------------------------------------------------
// lr_load: line setup
// orders the endpoints by x, derives spans, octant bits and the first error term
// ----------------------------------------------------------------------------
module lr_load import lr_pkg::*; (
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  output line_t  line_o
);

  coord_t ax, ay, bx, by;
  coord_t span_x, span_y, major, minor;
  logic   swap, y_down, steep;
  dec_t   major_s, minor_s;

  always_comb begin
    swap   = start_x_i > end_x_i;
    ax     = swap ? end_x_i   : start_x_i;
    ay     = swap ? end_y_i   : start_y_i;
    bx     = swap ? start_x_i : end_x_i;
    by     = swap ? start_y_i : end_y_i;
    span_x = bx - ax;
    y_down = by < ay;
    span_y = y_down ? (ay - by) : (by - ay);
    steep  = span_y > span_x;
    major  = steep ? span_y : span_x;
    minor  = steep ? span_x : span_y;
    major_s = $signed({{(DEC_BITS-COORD_BITS){1'b0}}, major});
    minor_s = $signed({{(DEC_BITS-COORD_BITS-1){1'b0}}, minor, 1'b0});

    line_o.cur_x    = ax;
    line_o.cur_y    = ay;
    line_o.stop_x   = bx;
    line_o.stop_y   = by;
    line_o.span_x   = span_x;
    line_o.span_y   = span_y;
    line_o.decision = minor_s - major_s;
    line_o.y_down   = y_down;
    line_o.steep    = steep;
  end

endmodule

@@ src/lr_step.sv @@
// ----------------------------------------------------------------------------
// lr_step: one Bresenham step
// gives the current pixel with its end mark and the line state after the step
// ----------------------------------------------------------------------------
module lr_step import lr_pkg::*; (
  input  line_t  line_i,
  output pixel_t pixel_o,
  output line_t  line_o
);

  logic   last, dec_pos;
  coord_t y_next, x_next;
  dec_t   twice_x, twice_y, dec_adj;

  always_comb begin
    last    = line_i.steep ? (line_i.cur_y == line_i.stop_y)
                           : (line_i.cur_x == line_i.stop_x);
    // strictly positive error term
    dec_pos = !line_i.decision[DEC_BITS-1] && (line_i.decision != '0);
    y_next  = line_i.y_down ? (line_i.cur_y - COORD_BITS'(1))
                            : (line_i.cur_y + COORD_BITS'(1));
    x_next  = line_i.cur_x + COORD_BITS'(1);
    twice_x = $signed({{(DEC_BITS-COORD_BITS-1){1'b0}}, line_i.span_x, 1'b0});
    twice_y = $signed({{(DEC_BITS-COORD_BITS-1){1'b0}}, line_i.span_y, 1'b0});

    pixel_o.x    = line_i.cur_x;
    pixel_o.y    = line_i.cur_y;
    pixel_o.last = last;

    line_o = line_i;
    if (line_i.steep) begin
      dec_adj         = dec_pos ? (line_i.decision - twice_y) : line_i.decision;
      line_o.decision = dec_adj + twice_x;
      line_o.cur_x    = dec_pos ? x_next : line_i.cur_x;
      line_o.cur_y    = y_next;
    end else begin
      dec_adj         = dec_pos ? (line_i.decision - twice_x) : line_i.decision;
      line_o.decision = dec_adj + twice_y;
      line_o.cur_y    = dec_pos ? y_next : line_i.cur_y;
      line_o.cur_x    = x_next;
    end
  end

endmodule

@@ src/line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// line_rasterizer: eight-octant Bresenham line rasterizer
// load transfers latch a line and color, advance transfers on an active line emit one pixel each
// ----------------------------------------------------------------------------
// a pixel appears on the master side in the cycle after its advance transfer
// throughput: one transfer per cycle unless the slave side stalls; the one-step error update sets the rate
// the slave side stalls only while a pixel sits in the output register unaccepted
// reset: asynchronous, active low; the block comes up idle with no pixel pending
// ----------------------------------------------------------------------------
module line_rasterizer import lr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_x, start_y, end_x, end_y, in_red, in_green, in_blue (low bit up)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic                  s_axis_tuser,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_x, pixel_y, out_red, out_green, out_blue (low bit up), zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // final_pixel
  output logic                  m_axis_tlast
);

  // input field unpacking
  coord_t start_x, start_y, end_x, end_y;
  color_t in_color;

  assign start_x        = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
  assign start_y        = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
  assign end_x          = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign end_y          = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
  assign in_color.red   = s_axis_tdata[4*COORD_BITS +: COLOR_BITS];
  assign in_color.green = s_axis_tdata[4*COORD_BITS + COLOR_BITS +: COLOR_BITS];
  assign in_color.blue  = s_axis_tdata[4*COORD_BITS + 2*COLOR_BITS +: COLOR_BITS];

  // line state and output register
  line_t  line_q, line_d;
  color_t color_q, color_d;
  logic   active_q, active_d;
  logic   out_valid_q, out_valid_d;
  pixel_t pix_q, pix_d;
  color_t pix_color_q, pix_color_d;

  line_t  load_line, step_line;
  pixel_t step_pix;

  logic s_xfer, cmd_load, cmd_adv;

  lr_load u_load (
    .start_x_i (start_x),
    .start_y_i (start_y),
    .end_x_i   (end_x),
    .end_y_i   (end_y),
    .line_o    (load_line)
  );

  lr_step u_step (
    .line_i  (line_q),
    .pixel_o (step_pix),
    .line_o  (step_line)
  );

  // accept whenever the output register is empty or drains this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign cmd_load      = s_xfer && (s_axis_tuser == FUNC_LOAD);
  // an advance while idle is dropped
  assign cmd_adv       = s_xfer && (s_axis_tuser == FUNC_ADVANCE) && active_q;

  always_comb begin
    line_d      = line_q;
    color_d     = color_q;
    active_d    = active_q;
    pix_d       = pix_q;
    pix_color_d = pix_color_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    if (cmd_load) begin
      // a load abandons any line in progress
      line_d   = load_line;
      color_d  = in_color;
      active_d = 1'b1;
    end else if (cmd_adv) begin
      line_d      = step_line;
      pix_d       = step_pix;
      pix_color_d = color_q;
      out_valid_d = 1'b1;
      // end point reached, line is done
      if (step_pix.last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, meaningful only under active_q / out_valid_q
  always_ff @(posedge clk_i) begin
    line_q      <= line_d;
    color_q     <= color_d;
    pix_q       <= pix_d;
    pix_color_q <= pix_color_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = pix_q.last;
  assign m_axis_tdata  = OUT_DATA_W'({pix_color_q.blue, pix_color_q.green,
                                      pix_color_q.red, pix_q.y, pix_q.x});

  // a load always leaves a line active
  a_load_activates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_load |=> active_q)
    else $error("load transfer did not activate a line");

  // an advance while idle leaves no pixel behind
  a_idle_advance_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && (s_axis_tuser == FUNC_ADVANCE) && !active_q) |=> !m_axis_tvalid)
    else $error("advance while idle produced a pixel");

  // the final pixel of a line ends it
  a_final_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_adv && step_pix.last) |=> (!active_q && m_axis_tvalid && m_axis_tlast))
    else $error("final pixel did not close the line");

  // on a steep line every non-final step moves y
  a_steep_moves_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_adv && line_q.steep && !step_pix.last) |=> !$stable(line_q.cur_y))
    else $error("steep step left y unchanged");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the line rasterizer
// a queue of load and advance commands feeds a stream driver, a bresenham
// predictor works out every pixel at its transfer, and a monitor compares the
// pixels that leave the block, field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import lr_pkg::*;

  localparam int CMAX        = (1 << COORD_BITS) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;
  localparam int LIMIT       = 200000;

  // master side tdata layout, low bit up
  localparam int PX_LSB = 0;
  localparam int PY_LSB = COORD_BITS;
  localparam int PR_LSB = 2 * COORD_BITS;
  localparam int PG_LSB = PR_LSB + COLOR_BITS;
  localparam int PB_LSB = PG_LSB + COLOR_BITS;

  typedef struct {
    logic                  func;
    coord_t                sx;
    coord_t                sy;
    coord_t                ex;
    coord_t                ey;
    logic [COLOR_BITS-1:0] r;
    logic [COLOR_BITS-1:0] g;
    logic [COLOR_BITS-1:0] b;
  } cmd_t;

  typedef struct {
    coord_t                x;
    coord_t                y;
    logic [COLOR_BITS-1:0] r;
    logic [COLOR_BITS-1:0] g;
    logic [COLOR_BITS-1:0] b;
    logic                  last;
  } pix_exp_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = FUNC_ADVANCE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  cmd_t     cmd_q[$];
  pix_exp_t pixel_exp_q[$];
  cmd_t     cmd_on_bus;

  int phase         = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 68;
  int err_cnt       = 0;
  int cycle_cnt     = 0;
  int hold_cnt      = 0;
  bit hold_done     = 1'b0;

  // predictor copy of the line state
  coord_t ln_x, ln_y, ln_stop_x, ln_stop_y;
  int     ln_span_x, ln_span_y, ln_err;
  logic   ln_y_down, ln_steep, ln_active;
  color_t ln_color;

  always #5 clk_i = ~clk_i;

  line_rasterizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  // bresenham step of the predictor for one accepted command
  task automatic raster_apply(input cmd_t c);
    pix_exp_t p;
    coord_t   ax, ay, bx, by;
    if (c.func == FUNC_LOAD) begin
      // swap so that x never decreases along the line
      if (c.sx > c.ex) begin
        ax = c.ex; ay = c.ey; bx = c.sx; by = c.sy;
      end else begin
        ax = c.sx; ay = c.sy; bx = c.ex; by = c.ey;
      end
      ln_x      = ax;
      ln_y      = ay;
      ln_stop_x = bx;
      ln_stop_y = by;
      ln_span_x = int'(bx) - int'(ax);
      ln_y_down = (by < ay);
      ln_span_y = ln_y_down ? int'(ay) - int'(by) : int'(by) - int'(ay);
      ln_steep  = (ln_span_y > ln_span_x);
      ln_err    = ln_steep ? 2 * ln_span_x - ln_span_y : 2 * ln_span_y - ln_span_x;
      ln_color.red   = c.r;
      ln_color.green = c.g;
      ln_color.blue  = c.b;
      ln_active = 1'b1;
    end else if (ln_active) begin
      p.x    = ln_x;
      p.y    = ln_y;
      p.r    = ln_color.red;
      p.g    = ln_color.green;
      p.b    = ln_color.blue;
      p.last = ln_steep ? (ln_y == ln_stop_y) : (ln_x == ln_stop_x);
      pixel_exp_q.push_back(p);
      if (p.last) begin
        ln_active = 1'b0;
      end else if (ln_steep) begin
        if (ln_err > 0) begin
          ln_x   = ln_x + COORD_BITS'(1);
          ln_err = ln_err - 2 * ln_span_y;
        end
        ln_err = ln_err + 2 * ln_span_x;
        ln_y   = ln_y_down ? ln_y - COORD_BITS'(1) : ln_y + COORD_BITS'(1);
      end else begin
        // minor axis steps only on a strictly positive error term
        if (ln_err > 0) begin
          ln_y   = ln_y_down ? ln_y - COORD_BITS'(1) : ln_y + COORD_BITS'(1);
          ln_err = ln_err - 2 * ln_span_x;
        end
        ln_err = ln_err + 2 * ln_span_y;
        ln_x   = ln_x + COORD_BITS'(1);
      end
    end
  endtask

  task automatic push_cmd(input logic func, input int sx, input int sy, input int ex,
                          input int ey, input int r, input int g, input int b);
    cmd_t c;
    c.func = func;
    c.sx = coord_t'(sx);
    c.sy = coord_t'(sy);
    c.ex = coord_t'(ex);
    c.ey = coord_t'(ey);
    c.r  = r[COLOR_BITS-1:0];
    c.g  = g[COLOR_BITS-1:0];
    c.b  = b[COLOR_BITS-1:0];
    cmd_q.push_back(c);
  endtask

  // advance commands carry random payload, which the block must ignore
  task automatic push_adv(input int n);
    for (int i = 0; i < n; i++) begin
      push_cmd(FUNC_ADVANCE, $urandom_range(CMAX), $urandom_range(CMAX),
               $urandom_range(CMAX), $urandom_range(CMAX),
               $urandom_range(255), $urandom_range(255), $urandom_range(255));
    end
  endtask

  function automatic int major_of(input int sx, input int sy, input int ex, input int ey);
    int dx, dy;
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    return (dx > dy) ? dx : dy;
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? CMAX : 0;
    return $urandom_range(CMAX);
  endfunction

  // move by d in a random direction, staying on screen
  function automatic int offset_coord(input int c, input int d);
    int v;
    v = $urandom_range(1) ? c + d : c - d;
    if (v > CMAX || v < 0) v = (c + d <= CMAX) ? c + d : c - d;
    if (v < 0) v = 0;
    return v;
  endfunction

  // mostly complete lines, some cut short or overrun, plus some noise
  task automatic gen_lines(input int target);
    int n, sx, sy, ex, ey, d_major, d_minor, m, adv, pick;
    n = 0;
    while (n < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_cmd(1'($urandom_range(1)), $urandom_range(CMAX), $urandom_range(CMAX),
                 $urandom_range(CMAX), $urandom_range(CMAX),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255));
        n++;
      end else begin
        if ($urandom_range(24) == 0) d_major = $urandom_range(400, 60);
        else d_major = $urandom_range(12);
        d_minor = $urandom_range(d_major);
        sx = pick_coord();
        sy = pick_coord();
        if ($urandom_range(1)) begin
          ex = offset_coord(sx, d_major);
          ey = offset_coord(sy, d_minor);
        end else begin
          ex = offset_coord(sx, d_minor);
          ey = offset_coord(sy, d_major);
        end
        m   = major_of(sx, sy, ex, ey);
        adv = m + 1;
        pick = $urandom_range(9);
        if (pick == 0) adv = $urandom_range(m);
        else if (pick == 1) adv = m + 1 + $urandom_range(2, 1);
        push_cmd(FUNC_LOAD, sx, sy, ex, ey,
                 $urandom_range(255), $urandom_range(255), $urandom_range(255));
        push_adv(adv);
        n += 1 + adv;
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || s_tvalid || pixel_exp_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // stream driver: predicts each command at its transfer, then offers the next
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) raster_apply(cmd_on_bus);
      if (!s_tvalid || s_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_bus = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cmd_on_bus.func;
          s_tdata  <= IN_DATA_W'({cmd_on_bus.b, cmd_on_bus.g, cmd_on_bus.r,
                                  cmd_on_bus.ey, cmd_on_bus.ex,
                                  cmd_on_bus.sy, cmd_on_bus.sx});
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // pixel receiver: random stalls, one long hold-off at the start of the last phase
  always @(posedge clk_i) begin
    if (phase == 2 && !hold_done) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // pixel monitor
  always @(posedge clk_i) begin
    pix_exp_t p;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pixel_exp_q.size() == 0) begin
        $error("pixel transfer with no pixel expected");
        err_cnt++;
      end else begin
        p = pixel_exp_q.pop_front();
        check_field("pixel_x", 32'(p.x), 32'(m_tdata[PX_LSB +: COORD_BITS]));
        check_field("pixel_y", 32'(p.y), 32'(m_tdata[PY_LSB +: COORD_BITS]));
        check_field("out_red", 32'(p.r), 32'(m_tdata[PR_LSB +: COLOR_BITS]));
        check_field("out_green", 32'(p.g), 32'(m_tdata[PG_LSB +: COLOR_BITS]));
        check_field("out_blue", 32'(p.b), 32'(m_tdata[PB_LSB +: COLOR_BITS]));
        check_field("final_pixel", 32'(p.last), 32'(m_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("line_rasterizer test failed");
      $finish;
    end
  end

  initial begin
    ln_x = '0; ln_y = '0; ln_stop_x = '0; ln_stop_y = '0;
    ln_span_x = 0; ln_span_y = 0; ln_err = 0;
    ln_y_down = 1'b0; ln_steep = 1'b0; ln_active = 1'b0;
    ln_color = '0;

    // directed: advance while idle, single point at the far corner
    push_adv(1);
    push_cmd(FUNC_LOAD, CMAX, CMAX, CMAX, CMAX, 255, 255, 255);
    push_adv(2);
    // horizontal, endpoints swapped
    push_cmd(FUNC_LOAD, 3, 7, 0, 7, 0, 0, 0);
    push_adv(4);
    // vertical with y going down
    push_cmd(FUNC_LOAD, 0, CMAX, 0, CMAX - 4, 170, 85, 1);
    push_adv(5);
    // 45 degrees
    push_cmd(FUNC_LOAD, 0, 0, 3, 3, 85, 170, 128);
    push_adv(4);
    // load while active abandons the line, next one has negative slope
    push_cmd(FUNC_LOAD, 10, 10, 20, 12, 1, 2, 3);
    push_adv(2);
    push_cmd(FUNC_LOAD, CMAX, 0, CMAX - 3, 3, 254, 127, 64);
    push_adv(4);
    gen_lines(230);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();
    phase = 1;
    send_idle_pct = 68;
    recv_idle_pct = 13;
    gen_lines(250);

    wait_drained();
    phase = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_lines(250);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && pixel_exp_q.size() == 0) begin
      $display("line_rasterizer test passed");
    end else begin
      $display("line_rasterizer test failed");
    end
    $finish;
  end

endmodule
